FILE: sv/sobel_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
// Holds field widths, register indexes, stage structs; no dependencies.
`default_nettype none

package sobel_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;

    localparam int PIX_W      = 8;
    localparam int THR_W      = 11;
    localparam int WID_W      = 11;
    localparam int HGT_W      = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_W      = 13;
    localparam int GRAD_W     = 11;
    localparam int SQ_W       = 20;
    localparam int MAG_W      = 21;
    localparam int THR_SQ_W   = 22;

    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = 3;

    localparam int THR_RESET    = 60;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // One window column, index 0 is the top row.
    typedef logic [2:0][PIX_W-1:0] t_col;

    typedef struct packed {
        logic valid;
        logic feed;
        logic drain;
        logic top_mid;
        logic emit;
        logic post;
        logic sel_l;
        logic last;
    } t_win_ctl;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic signed [GRAD_W-1:0] sx;
        logic signed [GRAD_W-1:0] sy;
    } t_grad;

    typedef struct packed {
        logic valid;
        logic edge_res;
        logic eof;
    } t_res;

endpackage

`default_nettype wire

FILE: sv/sobel_edge_threshold.sv
// Streaming 3x3 Sobel edge detector: one request per clock while the input is
// not stalled, pixels in raster order, border pixels replicated. The result for
// a pixel appears W+1 requests later (W = effective width), and the last W+1
// results of a frame come out on drain ticks, the final one flagged end_of_frame.
// A result released by an accepted request passes the control, gradient, square
// and queue registers on its way out; the rate is set by the two line stores, each
// doing one read and one write per cycle.
// Input stall rises only when eight results are in flight or queued unread.
// Writing width or height abandons the frame in progress. Line stores are not
// cleared after reset; no clearing pass is needed.
`default_nettype none

module sobel_edge_threshold #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [sobel_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sobel_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_cmd,
    input  wire logic [sobel_pkg::PIX_W-1:0]       i_pixel,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_edge_res,
    output logic                                   o_end_of_frame
);
    import sobel_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic                accept;
    logic                rd_en;
    logic [CW-1:0]       rd_addr;
    logic                reserve;
    t_win_ctl            ctl;
    logic [PIX_W-1:0]    s1_pix;
    logic [CW-1:0]       wr_addr;
    logic [THR_SQ_W-1:0] thr_sq;
    t_grad               grad;
    t_res                res;

    assign accept = i_in_valid && !o_in_stall;

    sobel_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_cmd      (i_cmd),
        .i_pixel    (i_pixel),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_reserve  (reserve),
        .o_ctl      (ctl),
        .o_pix      (s1_pix),
        .o_wr_addr  (wr_addr),
        .o_thr_sq   (thr_sq)
    );

    sobel_win #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_win (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_ctl     (ctl),
        .i_pix     (s1_pix),
        .i_wr_addr (wr_addr),
        .o_grad    (grad)
    );

    sobel_mag u_mag (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_grad   (grad),
        .i_thr_sq (thr_sq),
        .o_res    (res)
    );

    sobel_ofifo u_ofifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_reserve   (reserve),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_edge_res  (o_edge_res),
        .o_eof       (o_end_of_frame)
    );

    // Every queued result traces back to a slot reserved by an earlier accepted request.
    a_push_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> $past(reserve, 3))
        else $error("result pushed without a reserved slot");

    // Every reserved slot is filled once its request has passed the control, gradient and square registers.
    a_slot_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reserve |-> ##3 res.valid)
        else $error("reserved slot never filled");

    // End of frame comes only from the final drain tick, which moves no column.
    a_eof_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && res.eof) |-> $past(ctl.valid && !ctl.feed, 2))
        else $error("end of frame on a result that is not the final drain");

endmodule

`default_nettype wire

FILE: sv/sobel_ctrl.sv
// Input decode and frame position tracking, plus the configuration registers.
// Issues line store reads and the stage 1 control word. Uses sobel_pkg.
`default_nettype none

module sobel_ctrl #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [sobel_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sobel_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                                i_accept,
    input  wire logic                                i_cmd,
    input  wire logic [sobel_pkg::PIX_W-1:0]         i_pixel,
    output logic                                     o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]             o_rd_addr,
    output logic                                     o_reserve,
    output sobel_pkg::t_win_ctl                      o_ctl,
    output logic [sobel_pkg::PIX_W-1:0]              o_pix,
    output logic [$clog2(MAX_WIDTH)-1:0]             o_wr_addr,
    output logic [sobel_pkg::THR_SQ_W-1:0]           o_thr_sq
);
    import sobel_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [CW-1:0]       r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [WW-1:0]       r_eff_w;
    logic [HGT_W-1:0]    r_eff_h;
    logic [THR_SQ_W-1:0] r_thr_sq;
    t_win_ctl            r_ctl, n_ctl;
    logic [PIX_W-1:0]    r_pix;
    logic [CW-1:0]       r_wr_addr;

    logic [ROW_W-1:0]    h_ext;
    logic                restart;
    logic [CW-1:0]       c0;
    logic [ROW_W-1:0]    r0;
    logic                is_feed;
    logic                is_final;
    logic                emit_a;
    logic                emit_b;
    logic                wrap;
    logic                geom_wr;
    logic [WID_W-1:0]    wval;
    logic [HGT_W-1:0]    hval;
    logic [THR_W-1:0]    tval;
    logic [THR_SQ_W-1:0] thr_prod;

    always_comb begin
        h_ext    = ROW_W'(r_eff_h);
        // A pixel after the frame is fully received starts a new frame.
        restart  = (i_cmd == CMD_PIXEL) && (r_row >= h_ext);
        c0       = restart ? '0 : r_col;
        r0       = restart ? '0 : r_row;
        is_feed  = (i_cmd == CMD_PIXEL) || (r_row == h_ext);
        is_final = (i_cmd == CMD_DRAIN) && (r_row > h_ext);
        emit_a   = is_feed && (c0 == '0) && (r0 >= ROW_W'(2));
        emit_b   = is_feed && (c0 != '0) && (r0 != '0);
        wrap     = (WW'(c0) + WW'(1)) >= r_eff_w;

        n_ctl.valid   = is_feed || is_final;
        n_ctl.feed    = is_feed;
        n_ctl.drain   = (i_cmd == CMD_DRAIN);
        n_ctl.top_mid = (r0 <= ROW_W'(1));
        n_ctl.emit    = emit_a || emit_b || is_final;
        n_ctl.post    = emit_b;
        n_ctl.sel_l   = emit_b ? (c0 >= CW'(2)) : (r_eff_w != WW'(1));
        n_ctl.last    = is_final;

        geom_wr = i_cfg_we && ((i_cfg_idx == REG_WIDTH) || (i_cfg_idx == REG_HEIGHT));

        n_col = r_col;
        n_row = r_row;
        if (geom_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (i_accept) begin
            if (is_final) begin
                n_col = '0;
                n_row = '0;
            end else if (is_feed) begin
                if (wrap) begin
                    n_col = '0;
                    n_row = r0 + ROW_W'(1);
                end else begin
                    n_col = c0 + CW'(1);
                    n_row = r0;
                end
            end
        end

        wval     = i_cfg_data[WID_W-1:0];
        hval     = i_cfg_data[HGT_W-1:0];
        tval     = i_cfg_data[THR_W-1:0];
        thr_prod = THR_SQ_W'(tval) * THR_SQ_W'(tval);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_eff_w  <= WW'(W_RST);
            r_eff_h  <= HGT_W'(HEIGHT_RESET);
            r_thr_sq <= THR_SQ_W'(THR_RESET * THR_RESET);
            r_ctl    <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_ctl <= i_accept ? n_ctl : '0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESH: begin
                        r_thr_sq <= thr_prod;
                    end
                    REG_WIDTH: begin
                        // Zero acts as one, oversize saturates to the line store depth.
                        if (wval == '0) begin
                            r_eff_w <= WW'(1);
                        end else if (32'(wval) >= MAX_WIDTH) begin
                            r_eff_w <= WW'(MAX_WIDTH);
                        end else begin
                            r_eff_w <= WW'(wval);
                        end
                    end
                    REG_HEIGHT: begin
                        r_eff_h <= (hval == '0) ? HGT_W'(1) : hval;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix     <= i_pixel;
        r_wr_addr <= c0;
    end

    assign o_rd_en   = i_accept && is_feed;
    assign o_rd_addr = c0;
    assign o_reserve = i_accept && n_ctl.emit;
    assign o_ctl     = r_ctl;
    assign o_pix     = r_pix;
    assign o_wr_addr = r_wr_addr;
    assign o_thr_sq  = r_thr_sq;

endmodule

`default_nettype wire

FILE: sv/sobel_win.sv
// Line stores, 3x3 window and the Sobel sums, registered into the gradient stage.
// Takes the stage 1 control word from sobel_ctrl. Uses sobel_pkg.
`default_nettype none

module sobel_win #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    input  wire sobel_pkg::t_win_ctl           i_ctl,
    input  wire logic [sobel_pkg::PIX_W-1:0]   i_pix,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  i_wr_addr,
    output sobel_pkg::t_grad                   o_grad
);
    import sobel_pkg::*;

    logic [PIX_W-1:0] r_line_up  [MAX_WIDTH];
    logic [PIX_W-1:0] r_line_mid [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_up;
    logic [PIX_W-1:0] r_rd_mid;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_up;
    logic [PIX_W-1:0] r_fwd_mid;
    t_col             r_win0, r_win1, r_win2;
    t_grad            r_grad, n_grad;

    logic             wr_en;
    logic [PIX_W-1:0] a_val, b_val, p_val;
    t_col             new_col, col_l, col_c, col_r;
    logic [9:0]       sum_l, sum_r, sum_t, sum_b;

    always_comb begin
        wr_en = i_ctl.valid && i_ctl.feed;
        // Take the value written on the same edge as the read.
        a_val = r_fwd ? r_fwd_up  : r_rd_up;
        b_val = r_fwd ? r_fwd_mid : r_rd_mid;
        // Drain ticks replicate the last row into the bottom.
        p_val = i_ctl.drain ? b_val : i_pix;

        new_col[0] = i_ctl.top_mid ? b_val : a_val;
        new_col[1] = b_val;
        new_col[2] = p_val;

        col_l = i_ctl.sel_l ? r_win1 : r_win2;
        col_c = r_win2;
        col_r = i_ctl.post ? new_col : r_win2;

        sum_l = 10'(col_l[0]) + {1'b0, col_l[1], 1'b0} + 10'(col_l[2]);
        sum_r = 10'(col_r[0]) + {1'b0, col_r[1], 1'b0} + 10'(col_r[2]);
        sum_t = 10'(col_l[0]) + {1'b0, col_c[0], 1'b0} + 10'(col_r[0]);
        sum_b = 10'(col_l[2]) + {1'b0, col_c[2], 1'b0} + 10'(col_r[2]);

        n_grad.valid = i_ctl.valid && i_ctl.emit;
        n_grad.last  = i_ctl.last;
        n_grad.sx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
        n_grad.sy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_up[i_wr_addr]  <= b_val;
            r_line_mid[i_wr_addr] <= p_val;
        end
        if (i_rd_en) begin
            r_rd_up   <= r_line_up[i_rd_addr];
            r_rd_mid  <= r_line_mid[i_rd_addr];
            r_fwd_up  <= b_val;
            r_fwd_mid <= p_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd  <= 1'b0;
            r_win0 <= '0;
            r_win1 <= '0;
            r_win2 <= '0;
            r_grad <= '0;
        end else begin
            if (i_rd_en) begin
                r_fwd <= wr_en && (i_rd_addr == i_wr_addr);
            end
            if (wr_en) begin
                r_win0 <= r_win1;
                r_win1 <= r_win2;
                r_win2 <= new_col;
            end
            r_grad <= n_grad;
        end
    end

    assign o_grad = r_grad;

endmodule

`default_nettype wire

FILE: sv/sobel_mag.sv
// Squares the gradient components and compares the magnitude with the threshold.
// Fed by sobel_win, feeds sobel_ofifo. Uses sobel_pkg.
`default_nettype none

module sobel_mag (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sobel_pkg::t_grad                i_grad,
    input  wire logic [sobel_pkg::THR_SQ_W-1:0]  i_thr_sq,
    output sobel_pkg::t_res                      o_res
);
    import sobel_pkg::*;

    logic                       r_sq_v;
    logic                       r_sq_last;
    logic [SQ_W-1:0]            r_sqx;
    logic [SQ_W-1:0]            r_sqy;
    logic signed [2*GRAD_W-1:0] prod_x;
    logic signed [2*GRAD_W-1:0] prod_y;
    logic [MAG_W-1:0]           mag;

    always_comb begin
        prod_x = i_grad.sx * i_grad.sx;
        prod_y = i_grad.sy * i_grad.sy;
        mag    = MAG_W'(r_sqx) + MAG_W'(r_sqy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else begin
            r_sq_v <= i_grad.valid;
        end
    end

    // Each square stays below 2^20 since a component is at most 1020 in size.
    always_ff @(posedge i_clk) begin
        r_sq_last <= i_grad.last;
        r_sqx     <= prod_x[SQ_W-1:0];
        r_sqy     <= prod_y[SQ_W-1:0];
    end

    assign o_res.valid    = r_sq_v;
    assign o_res.edge_res = THR_SQ_W'(mag) > i_thr_sq;
    assign o_res.eof      = r_sq_last;

endmodule

`default_nettype wire

FILE: sv/sobel_ofifo.sv
// Result queue with slot reservation, so a result in flight always finds a free slot.
// A slot is reserved per request that will give a result. Uses sobel_pkg.
`default_nettype none

module sobel_ofifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_reserve,
    input  wire sobel_pkg::t_res i_res,
    input  wire logic            i_out_stall,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output logic                 o_edge_res,
    output logic                 o_eof
);
    import sobel_pkg::*;

    localparam int CNT_W = OFIFO_AW + 1;

    logic [1:0]       r_mem [OFIFO_DEPTH];
    logic [CNT_W-1:0] r_wr, r_rd, r_used;
    logic             pop;

    assign o_out_valid = (r_wr != r_rd);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_used == CNT_W'(OFIFO_DEPTH));
    assign o_edge_res  = r_mem[r_rd[OFIFO_AW-1:0]][1];
    assign o_eof       = r_mem[r_rd[OFIFO_AW-1:0]][0];

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_mem[r_wr[OFIFO_AW-1:0]] <= {i_res.edge_res, i_res.eof};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_used <= '0;
        end else begin
            if (i_res.valid) begin
                r_wr <= r_wr + CNT_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + CNT_W'(1);
            end
            r_used <= r_used + CNT_W'(i_reserve) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

FILE: test/tb_sobel_edge_threshold.sv
// Self-checking testbench for sobel_edge_threshold: drives raster pixels and
// drain ticks, predicts each edge flag from its own behavioral filter model.
// Depends on sobel_pkg (sv/sobel_pkg.sv) and the sobel_edge_threshold RTL.

module tb_sobel_edge_threshold;
    import sobel_pkg::*;

    localparam int LINE_DEPTH     = MAX_WIDTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 160;
    localparam int MAX_REPORTS    = 40;
    localparam int PHASE_ITEMS    = 150;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic edge_res;
        logic eof;
    } t_edge_flag;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_cmd;
    logic [PIX_W-1:0]      i_pixel;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_edge_res;
    logic                  o_end_of_frame;

    // Predicted filter state
    logic [THR_W-1:0]       thr_q;
    logic [WID_W-1:0]       wid_q;
    logic [HGT_W-1:0]       hgt_q;
    logic [PIX_W-1:0]       upper_row [LINE_DEPTH];
    logic [PIX_W-1:0]       middle_row [LINE_DEPTH];
    logic [2:0][PIX_W-1:0]  win [3];
    int unsigned            col_q;
    int unsigned            row_q;
    t_edge_flag             edge_queue [$];
    t_edge_flag             seen_flag;

    int fail_count    = 0;
    int live_items    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    sobel_edge_threshold uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_pixel        (i_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_edge_res     (o_edge_res),
        .o_end_of_frame (o_end_of_frame)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned eff_width();
        if (wid_q == 0) return 1;
        if (wid_q > LINE_DEPTH) return LINE_DEPTH;
        return wid_q;
    endfunction

    function automatic int unsigned eff_height();
        return (hgt_q == 0) ? 1 : hgt_q;
    endfunction

    function automatic void restart_frame();
        col_q = 0;
        row_q = 0;
    endfunction

    // Sobel sums over columns li/ci/ri of the window, then the squared compare.
    function automatic void grade_window(int li, int ci, int ri, logic last);
        int sx;
        int sy;
        int mag;
        int lim;
        t_edge_flag res;
        sx = int'(win[ri][0]) + 2 * int'(win[ri][1]) + int'(win[ri][2])
           - int'(win[li][0]) - 2 * int'(win[li][1]) - int'(win[li][2]);
        sy = int'(win[li][2]) + 2 * int'(win[ci][2]) + int'(win[ri][2])
           - int'(win[li][0]) - 2 * int'(win[ci][0]) - int'(win[ri][0]);
        mag = sx * sx + sy * sy;
        lim = int'(thr_q) * int'(thr_q);
        res.edge_res = (mag > lim);
        res.eof = last;
        edge_queue = {edge_queue, res};
    endfunction

    function automatic void feed_pixel(logic [PIX_W-1:0] pix);
        int unsigned w;
        int unsigned r;
        int unsigned c;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] mid;
        w = eff_width();
        r = row_q;
        c = col_q % LINE_DEPTH;
        // first column of a row closes out the right border of the row above
        if (c == 0 && r >= 2) grade_window((w >= 2) ? 1 : 2, 2, 2, 1'b0);
        above = upper_row[c];
        mid = middle_row[c];
        upper_row[c] = mid;
        middle_row[c] = pix;
        win[0] = win[1];
        win[1] = win[2];
        win[2][0] = (r <= 1) ? mid : above;
        win[2][1] = mid;
        win[2][2] = pix;
        if (c >= 1 && r >= 1) grade_window((c >= 2) ? 0 : 1, 1, 2, 1'b0);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        col_q = c;
        row_q = r;
    endfunction

    // Returns 0 when the request is ignored by the block.
    function automatic bit predict_request(logic cmd, logic [PIX_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        w = eff_width();
        h = eff_height();
        if (cmd == CMD_PIXEL) begin
            if (row_q >= h) restart_frame();
            feed_pixel(pix);
            return 1'b1;
        end
        if (row_q < h) return 1'b0;
        // bottom border: replay the last row from the middle store
        if (row_q == h && col_q < w) begin
            feed_pixel(middle_row[col_q % LINE_DEPTH]);
        end else begin
            grade_window((w >= 2) ? 1 : 2, 2, 2, 1'b1);
            restart_frame();
        end
        return 1'b1;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_THRESH: thr_q = data[THR_W-1:0];
            REG_WIDTH: begin
                wid_q = data[WID_W-1:0];
                restart_frame();
            end
            REG_HEIGHT: begin
                hgt_q = data[HGT_W-1:0];
                restart_frame();
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic got, logic want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s got %0b want %0b", $time, what, got, want);
    endtask

    task automatic send_request(logic cmd, logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_pixel <= pix;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_request(cmd, pix)) live_items++;
    endtask

    task automatic send_drains(int n);
        repeat (n) send_request(CMD_DRAIN, PIX_W'($urandom_range(255)));
    endtask

    // Hold off until every predicted result is out, then let the pipe settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (edge_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(int pat, int unsigned idx);
        case (pat)
            0: return PIX_W'($urandom_range(255));
            1: return $urandom_range(1) ? 8'hFF : 8'h00;
            2: return PIX_W'(118 + $urandom_range(8));
            default: return PIX_W'(idx * 37 + 11);
        endcase
    endfunction

    task automatic test_defaults();
        send_idle_pct = 0;
        stall_pct = 0;
        // drain while idle: ignore
        send_request(CMD_DRAIN, 8'hA5);
        wait_idle();
        write_reg(REG_WIDTH, 12'd3);
        write_reg(REG_HEIGHT, 12'd2);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_PIXEL, 8'hFF);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_PIXEL, 8'hFF);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_DRAIN, 8'h5A);
        send_request(CMD_PIXEL, 8'hFF);
        send_drains(4);
    endtask

    task automatic test_single_pixel();
        wait_idle();
        write_reg(REG_THRESH, 12'd0);
        write_reg(REG_WIDTH, 12'd0);
        write_reg(REG_HEIGHT, 12'd0);
        send_request(CMD_PIXEL, 8'hFF);
        send_drains(3);
    endtask

    task automatic test_threshold_extremes();
        wait_idle();
        // top bit of the data is outside the register: threshold becomes zero
        write_reg(REG_THRESH, 12'h800);
        write_reg(REG_SPARE, 12'h7FF);
        write_reg(REG_WIDTH, 12'd2);
        write_reg(REG_HEIGHT, 12'd2);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_PIXEL, 8'hFF);
        send_request(CMD_PIXEL, 8'hFF);
        send_request(CMD_PIXEL, 8'h00);
        send_drains(1);
        // pixel while draining starts a new frame
        send_request(CMD_PIXEL, 8'h01);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_PIXEL, 8'h01);
        send_drains(3);
        wait_idle();
        write_reg(REG_THRESH, 12'h7FF);
        write_reg(REG_HEIGHT, 12'd2);
        send_request(CMD_PIXEL, 8'hFF);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_PIXEL, 8'h00);
        send_request(CMD_PIXEL, 8'hFF);
        send_drains(3);
    endtask

    task automatic test_max_width();
        send_idle_pct = 10;
        stall_pct = 10;
        wait_idle();
        write_reg(REG_THRESH, CFG_DATA_W'($urandom_range(400)));
        write_reg(REG_WIDTH, 12'd2000);
        write_reg(REG_HEIGHT, 12'hFFF);
        // wrap into the second row so results show the saturated width
        for (int unsigned i = 0; i < LINE_DEPTH + 6; i++)
            send_request(CMD_PIXEL, pick_pixel(1, i));
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        wait_idle();
        write_reg(REG_THRESH, 12'd100);
        write_reg(REG_WIDTH, 12'd4);
        write_reg(REG_HEIGHT, 12'd6);
        hold_left = HOLD_CYCLES;
        for (int unsigned i = 0; i < 24; i++)
            send_request(CMD_PIXEL, pick_pixel(0, i));
        send_drains(5);
        // sender pause until everything is out, then another frame
        wait_idle();
        for (int unsigned i = 0; i < 24; i++)
            send_request(CMD_PIXEL, pick_pixel(1, i));
        send_drains(5);
    endtask

    task automatic test_random_frames(int send_pct, int stall_pct_v);
        int first;
        bit force_geom;
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned cut;
        int unsigned n_drain;
        int pat;
        int pick;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;
        send_idle_pct = send_pct;
        stall_pct = stall_pct_v;
        first = live_items;
        force_geom = 1'b1;
        while (live_items - first < PHASE_ITEMS) begin
            if (force_geom || $urandom_range(99) < 40) begin
                pick = $urandom_range(99);
                if (pick < 5) w_data = '0;
                else if (pick < 75) w_data = CFG_DATA_W'($urandom_range(1, 6));
                else if (pick < 95) w_data = CFG_DATA_W'($urandom_range(7, 24));
                else w_data = CFG_DATA_W'($urandom_range(25, 64));
                if ($urandom_range(99) < 5) w_data[CFG_DATA_W-1] = 1'b1;
                pick = $urandom_range(99);
                if (pick < 5) h_data = '0;
                else if (pick < 90) h_data = CFG_DATA_W'($urandom_range(1, 5));
                else h_data = CFG_DATA_W'($urandom_range(6, 12));
                wait_idle();
                if ($urandom_range(99) < 90)
                    write_reg(REG_THRESH, CFG_DATA_W'($urandom_range(500)));
                else
                    write_reg(REG_THRESH, CFG_DATA_W'($urandom_range(4095)));
                write_reg(REG_WIDTH, w_data);
                write_reg(REG_HEIGHT, h_data);
                force_geom = 1'b0;
            end
            w = eff_width();
            h = eff_height();
            total = w * h;
            pat = $urandom_range(3);
            cut = ($urandom_range(99) < 5) ? $urandom_range(total - 1) : total;
            for (int unsigned i = 0; i < cut; i++) begin
                if ($urandom_range(99) < 3)
                    send_request(CMD_DRAIN, PIX_W'($urandom_range(255)));
                if ($urandom_range(199) == 0) wait_idle();
                send_request(CMD_PIXEL, pick_pixel(pat, i));
            end
            // frame cut short: a geometry write abandons it
            if (cut < total) begin
                force_geom = 1'b1;
                continue;
            end
            pick = $urandom_range(99);
            n_drain = w + 1;
            if (pick < 8) n_drain = $urandom_range(w);
            else if (pick >= 94) n_drain = w + 1 + $urandom_range(1, 2);
            send_drains(n_drain);
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (edge_queue.size() == 0) begin
                report_mismatch("result with nothing pending, edge_res", o_edge_res, 1'b0);
            end else begin
                seen_flag = edge_queue.pop_front();
                if (o_edge_res !== seen_flag.edge_res)
                    report_mismatch("edge_res", o_edge_res, seen_flag.edge_res);
                if (o_end_of_frame !== seen_flag.eof)
                    report_mismatch("end_of_frame", o_end_of_frame, seen_flag.eof);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_THRESH;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_cmd <= CMD_PIXEL;
        i_pixel <= '0;
        thr_q = THR_W'(THR_RESET);
        wid_q = WID_W'(WIDTH_RESET);
        hgt_q = HGT_W'(HEIGHT_RESET);
        win = '{default: '0};
        restart_frame();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_single_pixel();
        test_threshold_extremes();
        test_max_width();
        test_backpressure();
        test_random_frames(0, 0);
        test_random_frames(55, 0);
        test_random_frames(0, 55);
        test_random_frames(24, 24);
        wait_idle();

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
